// File: design/l3crw_pkg.sv
package l3crw_pkg;

  localparam int RegCount = 12;
  localparam int IdxW     = 4;

  localparam logic [7:0] ExtAddrPrefix   = 8'hC0;
  localparam logic [7:0] ExtDataPrefix   = 8'hE0;
  localparam logic [7:0] BadReadValue    = 8'hFF;
  localparam logic [5:0] DeviceAddrReset = 6'd5;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_READ  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    TYPE_DATA0  = 2'd0,
    TYPE_DATA1  = 2'd1,
    TYPE_STATUS = 2'd2
  } bus_type_t;

  typedef struct packed {
    logic       transfer_valid;
    logic       bad_index;
    logic       last;
    logic [7:0] l3_address;
    logic [7:0] l3_data;
    logic [7:0] read_value;
  } result_t;

  typedef struct packed {
    result_t r0;
    result_t r1;
    logic    two;
  } enc_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] idx;
    logic [7:0]      data;
  } shadow_wr_t;

  function automatic logic [7:0] reset_value(input logic [IdxW-1:0] idx);
    logic [7:0] v;
    unique case (idx)
      4'd1:                v = 8'h40;
      4'd2:                v = 8'h80;
      4'd3, 4'd4, 4'd5:    v = 8'h04;
      4'd11:               v = 8'h83;
      default:             v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic bus_type_t bus_type(input logic [IdxW-1:0] idx);
    bus_type_t t;
    unique case (idx)
      4'd9:         t = TYPE_DATA1;
      4'd10, 4'd11: t = TYPE_STATUS;
      default:      t = TYPE_DATA0;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] ext_addr(input logic [IdxW-1:0] idx);
    logic [2:0] a;
    unique case (idx)
      4'd4:    a = 3'd1;
      4'd5:    a = 3'd2;
      4'd6:    a = 3'd4;
      4'd7:    a = 3'd5;
      4'd8:    a = 3'd6;
      default: a = 3'd0;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] fixed_bits(input logic [IdxW-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd1:         b = 8'h40;
      4'd2, 4'd11:  b = 8'h80;
      default:      b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: design/l3_codec_register_writer_unit.sv
// Channel | Dir | Signals                         | Contents (lowest bit up)
// s       | in  | s_tvalid s_tready s_tdata s_tuser | tdata: reg_index, write_value; tuser: kind
// m       | out | m_tvalid m_tready m_tdata m_tuser m_tlast
//         |     |                                 | tdata: l3_address, l3_data, read_value;
//         |     |                                 | tuser: transfer_valid, bad_index; tlast: last
// cfg     | in  | cfg_we cfg_wdata                | device_address
//
// Reads, bad indices and direct writes give one result each; extended writes give two,
// one per bus transfer, held in the single output register and its one-deep hold slot.
// The first result of a transaction appears the cycle after it is accepted.
// Reset loads the shadow copy with the device defaults and device_address with 5.
// Input is refused while the output register is stalled or the hold slot is full.
module l3_codec_register_writer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [3:0] reg_index, [11:4] write_value, [15:12] zero
  input  logic [0:0]  s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] l3_address, [15:8] l3_data, [23:16] read_value
  output logic [1:0]  m_tuser,   // [0] transfer_valid, [1] bad_index
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata
);

  logic                       accept;
  logic [5:0]                 device_address;
  logic [7:0]                 shadow_rd;
  l3crw_pkg::enc_t            enc;
  l3crw_pkg::shadow_wr_t      wr;
  l3crw_pkg::result_t         out;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= l3crw_pkg::DeviceAddrReset;
    end else if (cfg_we) begin
      device_address <= cfg_wdata;
    end
  end

  l3crw_shadow u_shadow (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_idx  (s_tdata[3:0]),
    .rd_data (shadow_rd)
  );

  l3crw_encode u_encode (
    .accept         (accept),
    .kind           (s_tuser[0]),
    .reg_index      (s_tdata[3:0]),
    .write_value    (s_tdata[11:4]),
    .device_address (device_address),
    .shadow_rd      (shadow_rd),
    .enc            (enc),
    .wr             (wr)
  );

  l3crw_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .enc       (enc),
    .m_tready  (m_tready),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out       (out)
  );

  assign m_tdata = {out.read_value, out.l3_data, out.l3_address};
  assign m_tuser = {out.bad_index, out.transfer_valid};
  assign m_tlast = out.last;

endmodule

// File: design/l3crw_shadow.sv
module l3crw_shadow (
  input  logic                       clk,
  input  logic                       rst,
  input  l3crw_pkg::shadow_wr_t      wr,
  input  logic [l3crw_pkg::IdxW-1:0] rd_idx,
  output logic [7:0]                 rd_data
);

  logic [7:0] regs [l3crw_pkg::RegCount];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < l3crw_pkg::RegCount; i++) begin
        regs[i] <= l3crw_pkg::reset_value(l3crw_pkg::IdxW'(i));
      end
    end else if (wr.en) begin
      regs[wr.idx] <= wr.data;
    end
  end

  assign rd_data = (rd_idx < l3crw_pkg::IdxW'(l3crw_pkg::RegCount)) ? regs[rd_idx] : 8'h00;

endmodule

// File: design/l3crw_encode.sv
module l3crw_encode (
  input  logic                       accept,
  input  logic                       kind,
  input  logic [l3crw_pkg::IdxW-1:0] reg_index,
  input  logic [7:0]                 write_value,
  input  logic [5:0]                 device_address,
  input  logic [7:0]                 shadow_rd,
  output l3crw_pkg::enc_t            enc,
  output l3crw_pkg::shadow_wr_t      wr
);

  logic bad;
  logic is_ext;

  assign bad    = reg_index >= l3crw_pkg::IdxW'(l3crw_pkg::RegCount);
  assign is_ext = (reg_index >= 4'd3) && (reg_index <= 4'd8);

  always_comb begin
    enc = '0;
    enc.r0.last = 1'b1;
    enc.r1.last = 1'b1;
    if (bad) begin
      enc.r0.bad_index  = 1'b1;
      enc.r0.read_value = l3crw_pkg::BadReadValue;
    end else if (l3crw_pkg::kind_t'(kind) == l3crw_pkg::KIND_READ) begin
      enc.r0.read_value = shadow_rd;
    end else if (is_ext) begin
      enc.two                = 1'b1;
      enc.r0.transfer_valid  = 1'b1;
      enc.r0.last            = 1'b0;
      enc.r0.l3_address      = {device_address, l3crw_pkg::TYPE_DATA0};
      enc.r0.l3_data         = l3crw_pkg::ExtAddrPrefix
                               | {5'b0, l3crw_pkg::ext_addr(reg_index)};
      enc.r1.transfer_valid  = 1'b1;
      enc.r1.l3_address      = {device_address, l3crw_pkg::TYPE_DATA0};
      enc.r1.l3_data         = l3crw_pkg::ExtDataPrefix | write_value;
    end else begin
      enc.r0.transfer_valid  = 1'b1;
      enc.r0.l3_address      = {device_address, l3crw_pkg::bus_type(reg_index)};
      enc.r0.l3_data         = write_value | l3crw_pkg::fixed_bits(reg_index);
    end
  end

  assign wr.en   = accept && !bad && (l3crw_pkg::kind_t'(kind) == l3crw_pkg::KIND_WRITE);
  assign wr.idx  = reg_index;
  assign wr.data = write_value;

endmodule

// File: design/l3crw_out_stage.sv
module l3crw_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  l3crw_pkg::enc_t   enc,
  input  logic              m_tready,
  output logic              in_ready,
  output logic              out_valid,
  output l3crw_pkg::result_t out
);

  logic               pend_valid;
  l3crw_pkg::result_t pend;

  assign in_ready = !pend_valid && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (accept) begin
      out_valid  <= 1'b1;
      out        <= enc.r0;
      pend_valid <= enc.two;
      pend       <= enc.r1;
    end else if (out_valid && m_tready) begin
      if (pend_valid) begin
        out        <= pend;
        pend_valid <= 1'b0;
      end else begin
        out_valid  <= 1'b0;
      end
    end
  end

  a_pend_needs_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("second transfer held without a first");

  a_pend_is_last: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> pend.last && !out.last)
    else $error("last flag misplaced across extended write");

  a_two_loads_pend: assert property (@(posedge clk) disable iff (rst)
    (accept && enc.two) |=> pend_valid && out_valid && out.transfer_valid)
    else $error("extended write did not queue its second transfer");

  a_pend_drains: assert property (@(posedge clk) disable iff (rst)
    (out_valid && m_tready && pend_valid) |=> out_valid && !pend_valid && out.last)
    else $error("second transfer lost on hand-over");

endmodule
